[design/fpcc_pkg.sv]
`timescale 1ns / 1ps
package fpcc_pkg;

   localparam int INTEGRAL_LIMIT = 1000000;
   localparam int DIV_W = 60;
   localparam int DIV_CW = 6;
   localparam int DIV_KSTEPS = 4;
   localparam logic [15:0] MILLI_SCALE = 16'd1000;
   // ceil(2^35 / 1000)
   localparam logic [25:0] RECIP_K = 26'd34359739;

   localparam logic [1:0] OP_UPDATE = 2'd0;
   localparam logic [1:0] OP_START  = 2'd1;
   localparam logic [1:0] OP_STOP   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_PARAM = 2'd1;
   localparam logic [1:0] ST_HW    = 2'd2;

   localparam logic [2:0] REG_KP       = 3'd0;
   localparam logic [2:0] REG_KI       = 3'd1;
   localparam logic [2:0] REG_KD       = 3'd2;
   localparam logic [2:0] REG_SETPOINT = 3'd3;
   localparam logic [2:0] REG_MAX      = 3'd4;

   typedef enum logic [2:0] {
      MUL_ERR_DT = 3'd0,
      MUL_DIFF_K = 3'd1,
      MUL_KP     = 3'd2,
      MUL_KI     = 3'd3,
      MUL_KD     = 3'd4
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        dec_param;
      logic        dec_fault;
      logic        do_start;
      logic        do_stop;
      mul_sel_type mul_sel;
      logic        mul_en;
      logic        int_wr;
      logic        lerr_wr;
      logic        div_start;
      logic        div_by_k;
      logic        der_wr;
      logic        sum_init;
      logic        sum_acc;
      logic        finish;
      logic        out_wr;
   } fpcc_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       dt_zero;
      logic       fault;
      logic       div_done;
      logic       div_busy;
      logic       out_busy;
   } fpcc_stat_type;

endpackage

[design/flow_pid_current_controller.sv]
`timescale 1ns / 1ps
// PID flow regulator commanding a motor current.
// Request channel (req_valid / req_stall): one beat carries an operation
// (update, start, stop), the measured flow, the elapsed milliseconds and the
// driver fault flag. A beat is taken when req_valid is high and req_stall low.
// Response channel (rsp_valid / rsp_stall): one beat per request with the new
// current command, a status code and the at-limit flag.
// CSR channel (csr_valid / csr_ready): writes gains, setpoint and current
// limit by index; always ready. Write only while no request is in flight.
// Start, stop, zero-dt, fault and unused-op requests pass from decode
// straight to the output state, which writes the response and goes idle.
// An update runs a shared 32x32 multiplier, a 60-bit radix-2 divide by the
// elapsed time and two divides by 1000 in 15-bit digits; the next beat is
// taken only after its response is written, one request at a time. The next
// request may be taken while a response still waits in the output register;
// a stalled response holds its data and the controller waits before writing
// the following one, adding the stalled time to its run.
// Reset (synchronous) restores the default gains and clears loop state.
module flow_pid_current_controller import fpcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [15:0] req_measured_flow,
   input  logic [15:0] req_elapsed_ms,
   input  logic        req_driver_fault,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_current_cmd,
   output logic [1:0]  rsp_status,
   output logic        rsp_at_limit,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   fpcc_cmd_type  cmd;
   fpcc_stat_type stat;

   assign csr_ready = 1'b1;

   fpcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   fpcc_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_op            (req_op),
      .req_measured_flow (req_measured_flow),
      .req_elapsed_ms    (req_elapsed_ms),
      .req_driver_fault  (req_driver_fault),
      .csr_wr            (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_current_cmd   (rsp_current_cmd),
      .rsp_status        (rsp_status),
      .rsp_at_limit      (rsp_at_limit)
   );
endmodule

[design/fpcc_div.sv]
`timescale 1ns / 1ps
module fpcc_div import fpcc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             by_k,
   input  logic [DIV_W-1:0] dividend,
   input  logic [15:0]      divisor,
   output logic             busy,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);
   logic [15:0]       rem_ff, rem_in, dvs_ff;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DIV_CW-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic              by_k_ff;
   logic [16:0]       trial, diff;
   logic [24:0]       kval;
   logic [50:0]       kprod;
   logic [14:0]       kq;
   logic [9:0]        krem;

   // divide by 1000 in 15-bit digits: the digit comes from a reciprocal
   // multiply, exact while the partial dividend stays below 2^25
   assign kval  = {rem_ff[9:0], quo_ff[DIV_W-1 -: 15]};
   assign kprod = 51'(kval) * 51'(RECIP_K);
   assign kq    = 15'(kprod >> 35);
   assign krem  = 10'(kval - 25'(kq) * 25'(MILLI_SCALE));

   // otherwise one quotient bit per cycle, restoring
   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff && by_k_ff) begin
         rem_in = {6'b0, krem};
         quo_in = {quo_ff[DIV_W-16:0], kq};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CW'(DIV_KSTEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (!diff[16]) begin
            rem_in = diff[15:0];
         end else begin
            rem_in = trial[15:0];
         end
         quo_in = {quo_ff[DIV_W-2:0], ~diff[16]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CW'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff  <= divisor;
         by_k_ff <= by_k;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

[design/fpcc_datapath.sv]
`timescale 1ns / 1ps
module fpcc_datapath import fpcc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  fpcc_cmd_type  cmd,
   output fpcc_stat_type stat,
   input  logic [1:0]    req_op,
   input  logic [15:0]   req_measured_flow,
   input  logic [15:0]   req_elapsed_ms,
   input  logic          req_driver_fault,
   input  logic          csr_wr,
   input  logic [2:0]    csr_index,
   input  logic [31:0]   csr_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [15:0]   rsp_current_cmd,
   output logic [1:0]    rsp_status,
   output logic          rsp_at_limit
);
   localparam logic signed [35:0] INT_HI = 36'(INTEGRAL_LIMIT);
   localparam logic signed [35:0] INT_LO = -INT_HI;

   logic [30:0] kp_ff, ki_ff, kd_ff;
   logic [15:0] setp_ff, max_ff;
   logic [1:0]  op_ff;
   logic [15:0] flow_ff, dt_ff;
   logic        fault_ff;

   logic signed [20:0] int_ff;
   logic signed [16:0] lerr_ff;
   logic [15:0]        drive_ff;
   logic               sat_ff;
   logic [1:0]         st_ff;

   logic signed [63:0] prod_ff, sum_ff;
   logic signed [28:0] deriv_ff;
   logic               neg_ff;
   logic               rsp_valid_ff;
   logic [15:0]        rsp_cur_ff;
   logic [1:0]         rsp_st_ff;
   logic               rsp_lim_ff;

   logic signed [16:0] err;
   logic signed [17:0] ediff;
   logic signed [31:0] mul_a, mul_b;
   logic signed [35:0] int_sum;
   logic               block;
   logic [63:0]        prod_abs;
   logic               div_busy, div_done;
   logic [DIV_W-1:0]   div_quo;
   logic [63:0]        quo_x;
   logic [47:0]        shifted;
   logic [15:0]        cmd_val;

   assign err   = $signed({1'b0, setp_ff}) - $signed({1'b0, flow_ff});
   assign ediff = 18'(err) - 18'(lerr_ff);

   always_comb begin
      mul_a = 32'(err);
      mul_b = $signed({16'b0, dt_ff});
      case (cmd.mul_sel)
         MUL_ERR_DT: begin
            mul_a = 32'(err);
            mul_b = $signed({16'b0, dt_ff});
         end
         MUL_DIFF_K: begin
            mul_a = 32'(ediff);
            mul_b = $signed({16'b0, MILLI_SCALE});
         end
         MUL_KP: begin
            mul_a = $signed({1'b0, kp_ff});
            mul_b = 32'(err);
         end
         MUL_KI: begin
            mul_a = $signed({1'b0, ki_ff});
            mul_b = 32'(int_ff);
         end
         MUL_KD: begin
            mul_a = $signed({1'b0, kd_ff});
            mul_b = 32'(deriv_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // anti-windup: hold the integral while pinned and the error pushes further out
   assign block = sat_ff && (((drive_ff >= max_ff) && (err > 0)) ||
                             ((drive_ff == 16'd0) && (err < 0)));
   assign int_sum  = 36'(int_ff) + prod_ff[35:0];
   assign prod_abs = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
   assign quo_x    = {{(64 - DIV_W){1'b0}}, div_quo};
   assign shifted  = sum_ff[63:16];
   assign cmd_val  = sum_ff[63] ? 16'd0 :
                     (shifted > {32'b0, max_ff}) ? max_ff : shifted[15:0];

   fpcc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .by_k     (cmd.div_by_k),
      .dividend (prod_abs[DIV_W-1:0]),
      .divisor  (cmd.div_by_k ? MILLI_SCALE : dt_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= 31'd65536;
         ki_ff        <= 31'd65536;
         kd_ff        <= 31'd0;
         setp_ff      <= 16'd0;
         max_ff       <= 16'd2000;
         int_ff       <= '0;
         lerr_ff      <= '0;
         drive_ff     <= '0;
         sat_ff       <= 1'b0;
         st_ff        <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr) begin
            case (csr_index)
               REG_KP:       kp_ff   <= csr_data[30:0];
               REG_KI:       ki_ff   <= csr_data[30:0];
               REG_KD:       kd_ff   <= csr_data[30:0];
               REG_SETPOINT: setp_ff <= csr_data[15:0];
               REG_MAX:      max_ff  <= csr_data[15:0];
               default: ;
            endcase
         end
         if (cmd.dec_param) begin
            st_ff <= ST_PARAM;
         end
         if (cmd.dec_fault) begin
            drive_ff <= '0;
            st_ff    <= ST_HW;
         end
         if (cmd.do_start) begin
            int_ff   <= '0;
            lerr_ff  <= '0;
            drive_ff <= '0;
            st_ff    <= ST_OK;
         end
         if (cmd.do_stop) begin
            drive_ff <= '0;
            st_ff    <= ST_OK;
         end
         if (cmd.int_wr && !block) begin
            if (int_sum > INT_HI) begin
               int_ff <= INT_HI[20:0];
            end else if (int_sum < INT_LO) begin
               int_ff <= INT_LO[20:0];
            end else begin
               int_ff <= int_sum[20:0];
            end
         end
         if (cmd.lerr_wr) begin
            lerr_ff <= err;
         end
         if (cmd.finish) begin
            drive_ff <= cmd_val;
            sat_ff   <= (cmd_val == 16'd0) || (cmd_val == max_ff);
            st_ff    <= ST_OK;
         end
         if (cmd.out_wr) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.load) begin
         op_ff    <= req_op;
         flow_ff  <= req_measured_flow;
         dt_ff    <= req_elapsed_ms;
         fault_ff <= req_driver_fault;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (cmd.div_start) begin
         neg_ff <= prod_ff[63];
      end
      if (cmd.der_wr) begin
         deriv_ff <= neg_ff ? -$signed({1'b0, div_quo[27:0]}) : $signed({1'b0, div_quo[27:0]});
      end
      if (cmd.sum_init) begin
         sum_ff <= prod_ff;
      end else if (cmd.sum_acc) begin
         sum_ff <= neg_ff ? sum_ff - $signed(quo_x) : sum_ff + $signed(quo_x);
      end
      if (cmd.out_wr) begin
         rsp_cur_ff <= drive_ff;
         rsp_st_ff  <= st_ff;
         rsp_lim_ff <= sat_ff;
      end
   end

   assign stat.op       = op_ff;
   assign stat.dt_zero  = (dt_ff == 16'd0);
   assign stat.fault    = fault_ff;
   assign stat.div_done = div_done;
   assign stat.div_busy = div_busy;
   assign stat.out_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_current_cmd = rsp_cur_ff;
   assign rsp_status      = rsp_st_ff;
   assign rsp_at_limit    = rsp_lim_ff;
endmodule

[design/fpcc_ctrl.sv]
`timescale 1ns / 1ps
module fpcc_ctrl import fpcc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  fpcc_stat_type stat,
   output fpcc_cmd_type  cmd
);
   typedef enum logic [14:0] {
      S_IDLE   = 15'b000000000000001,
      S_DECODE = 15'b000000000000010,
      S_ED     = 15'b000000000000100,
      S_INT    = 15'b000000000001000,
      S_DDIV   = 15'b000000000010000,
      S_DWAIT  = 15'b000000000100000,
      S_PM     = 15'b000000001000000,
      S_PS     = 15'b000000010000000,
      S_KIDIV  = 15'b000000100000000,
      S_KIWAIT = 15'b000001000000000,
      S_KDM    = 15'b000010000000000,
      S_KDDIV  = 15'b000100000000000,
      S_KDWAIT = 15'b001000000000000,
      S_FIN    = 15'b010000000000000,
      S_OUT    = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = MUL_ERR_DT;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_OUT;
            case (stat.op)
               OP_UPDATE: begin
                  if (stat.dt_zero) begin
                     cmd.dec_param = 1'b1;
                  end else if (stat.fault) begin
                     cmd.dec_fault = 1'b1;
                  end else begin
                     state_in = S_ED;
                  end
               end
               OP_START: cmd.do_start  = 1'b1;
               OP_STOP:  cmd.do_stop   = 1'b1;
               default:  cmd.dec_param = 1'b1;
            endcase
         end
         S_ED: begin
            cmd.mul_sel = MUL_ERR_DT;
            cmd.mul_en  = 1'b1;
            state_in    = S_INT;
         end
         S_INT: begin
            cmd.int_wr  = 1'b1;
            cmd.mul_sel = MUL_DIFF_K;
            cmd.mul_en  = 1'b1;
            cmd.lerr_wr = 1'b1;
            state_in    = S_DDIV;
         end
         S_DDIV: begin
            cmd.div_start = 1'b1;
            state_in      = S_DWAIT;
         end
         S_DWAIT: begin
            if (stat.div_done) begin
               cmd.der_wr = 1'b1;
               state_in   = S_PM;
            end
         end
         S_PM: begin
            cmd.mul_sel = MUL_KP;
            cmd.mul_en  = 1'b1;
            state_in    = S_PS;
         end
         S_PS: begin
            cmd.sum_init = 1'b1;
            cmd.mul_sel  = MUL_KI;
            cmd.mul_en   = 1'b1;
            state_in     = S_KIDIV;
         end
         S_KIDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_by_k  = 1'b1;
            state_in      = S_KIWAIT;
         end
         S_KIWAIT: begin
            if (stat.div_done) begin
               cmd.sum_acc = 1'b1;
               state_in    = S_KDM;
            end
         end
         S_KDM: begin
            cmd.mul_sel = MUL_KD;
            cmd.mul_en  = 1'b1;
            state_in    = S_KDDIV;
         end
         S_KDDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_by_k  = 1'b1;
            state_in      = S_KDWAIT;
         end
         S_KDWAIT: begin
            if (stat.div_done) begin
               cmd.sum_acc = 1'b1;
               state_in    = S_FIN;
            end
         end
         S_FIN: begin
            // clamp the completed sum into the new command
            cmd.finish = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            // hold the result until the output register is free
            if (!stat.out_busy) begin
               cmd.out_wr = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_DECODE)
      else $error("accepted beat did not reach decode");
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_wr |-> !stat.out_busy)
      else $error("result written over a stalled beat");
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !stat.div_busy)
      else $error("divider started while busy");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      cmd.out_wr |=> state_ff == S_IDLE)
      else $error("result write did not return to idle");
endmodule

[test/flow_pid_current_controller_tb.sv]
`timescale 1ns / 1ps
module flow_pid_current_controller_tb;
   import fpcc_pkg::*;

   // Loop-state model: each accepted request beat advances the predicted state
   // and queues the response beat it should produce.
   class pid_scoreboard;
      typedef struct {
         logic [15:0] cmd;
         logic [1:0]  st;
         logic        lim;
      } rsp_beat_type;

      longint kp, ki, kd, setpoint, imax;
      longint integ, prev_err, drive;
      bit     sat;
      rsp_beat_type pending[$];
      int     err_count;

      function void init();
         kp = 65536; ki = 65536; kd = 0; setpoint = 0; imax = 2000;
         integ = 0; prev_err = 0; drive = 0; sat = 0;
         err_count = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            REG_KP: kp = val[30:0];
            REG_KI: ki = val[30:0];
            REG_KD: kd = val[30:0];
            REG_SETPOINT: setpoint = val[15:0];
            REG_MAX: imax = val[15:0];
            default: ;
         endcase
      endfunction

      // Advance the loop by one request and queue its response beat.
      function void note_request(logic [1:0] op, logic [15:0] flow, logic [15:0] dt,
                                 logic fault);
         longint e, d, deriv, sum, cmd;
         logic [1:0] st;
         rsp_beat_type b;
         st = ST_OK;
         if (op == OP_UPDATE) begin
            if (dt == 0) begin
               st = ST_PARAM;
            end else if (fault) begin
               drive = 0;
               st = ST_HW;
            end else begin
               e = setpoint - longint'(flow);
               d = dt;
               // anti-windup: hold the integral while pinned at a rail
               if (!((sat && drive >= imax && e > 0) || (sat && drive == 0 && e < 0))) begin
                  integ = integ + e * d;
                  if (integ > INTEGRAL_LIMIT) integ = INTEGRAL_LIMIT;
                  if (integ < -INTEGRAL_LIMIT) integ = -INTEGRAL_LIMIT;
               end
               deriv = ((e - prev_err) * 1000) / d;
               prev_err = e;
               sum = kp * e + (ki * integ) / 1000 + (kd * deriv) / 1000;
               if (sum < 0) cmd = 0;
               else begin
                  cmd = sum >>> 16;
                  if (cmd > imax) cmd = imax;
               end
               sat = (cmd == 0) || (cmd == imax);
               drive = cmd & 16'hffff;
            end
         end else if (op == OP_START) begin
            integ = 0; prev_err = 0; drive = 0;
         end else if (op == OP_STOP) begin
            drive = 0;
         end else begin
            st = ST_PARAM;
         end
         b.cmd = drive[15:0];
         b.st = st;
         b.lim = sat;
         pending.push_back(b);
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
         err_count++;
      endtask

      task check_response(logic [15:0] cmd, logic [1:0] st, logic lim);
         rsp_beat_type b;
         if (pending.size() == 0) begin
            report("unexpected response", cmd, -1);
         end else begin
            b = pending.pop_front();
            if (cmd !== b.cmd) report("current_cmd", cmd, b.cmd);
            if (st !== b.st) report("status", st, b.st);
            if (lim !== b.lim) report("at_limit", lim, b.lim);
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_op;
   logic [15:0] req_measured_flow;
   logic [15:0] req_elapsed_ms;
   logic        req_driver_fault;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_current_cmd;
   logic [1:0]  rsp_status;
   logic        rsp_at_limit;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   pid_scoreboard loop_model;
   bit  idle_free;     // when set, neither side inserts idle cycles
   int  quiet_cycles;

   flow_pid_current_controller u_top (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Check each response beat as it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         loop_model.check_response(rsp_current_cmd, rsp_status, rsp_at_limit);
   end

   // Randomly stall the response side, except in the idle-free stretch.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !idle_free && ($urandom_range(99) < 35);
   end

   // Watchdog: count cycles with no beat on any channel. An update runs quietly,
   // and stalled responses lengthen the quiet stretch.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Hold a request beat until it is taken, after an optional random gap.
   // Valid stays up after the beat; the next call or a drain drops it.
   task send_request(logic [1:0] op, logic [15:0] flow, logic [15:0] dt, logic fault);
      while (!idle_free && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_measured_flow <= flow;
      req_elapsed_ms <= dt;
      req_driver_fault <= fault;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      loop_model.note_request(op, flow, dt, fault);
   endtask

   // Drop valid, drain every pending response, then let the block settle.
   task wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (loop_model.pending.size() != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   task write_reg(logic [2:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      loop_model.set_reg(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Gains are mostly moderate so the command lands inside its range; rare
   // extremes drive it hard into either rail.
   task random_config();
      write_reg(REG_KP, ($urandom_range(9) == 0) ? 32'h7fffffff : $urandom_range(200000));
      write_reg(REG_KI, ($urandom_range(9) == 0) ? $urandom : $urandom_range(200000));
      write_reg(REG_KD, ($urandom_range(9) == 0) ? $urandom : $urandom_range(20000));
      write_reg(REG_SETPOINT, ($urandom_range(7) == 0) ? $urandom : $urandom_range(300));
      write_reg(REG_MAX, ($urandom_range(7) == 0) ? $urandom : $urandom_range(5000));
   endtask

   // Mostly well-formed updates near the setpoint, with starts, stops,
   // faults, zero dt and the unused op mixed in.
   task random_request();
      int r;
      logic [15:0] flow;
      logic [15:0] dt;
      r = $urandom_range(99);
      flow = ($urandom_range(9) == 0) ? 16'($urandom)
             : 16'(loop_model.setpoint + $urandom_range(120) - 60);
      dt = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(50));
      if (r < 80) send_request(OP_UPDATE, flow, dt, $urandom_range(29) == 0);
      else if (r < 88) send_request(OP_START, 16'($urandom), 16'($urandom), 1'($urandom));
      else if (r < 95) send_request(OP_STOP, 16'($urandom), 16'($urandom), 1'($urandom));
      else send_request(2'd3, 16'($urandom), 16'($urandom), 1'($urandom));
   endtask

   initial begin
      loop_model = new();
      loop_model.init();
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_UPDATE;
      req_measured_flow = '0;
      req_elapsed_ms = '0;
      req_driver_fault = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      rsp_stall = 1'b0;
      idle_free = 1'b0;
      quiet_cycles = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: defaults, then field extremes and every special case.
      send_request(OP_UPDATE, 16'd0, 16'd0, 1'b0);       // zero dt
      send_request(OP_UPDATE, 16'd5, 16'd1, 1'b1);       // fault
      send_request(OP_UPDATE, 16'd0, 16'd0, 1'b1);       // zero dt wins over fault
      wait_drained();
      write_reg(REG_SETPOINT, 32'd100);
      send_request(OP_UPDATE, 16'd0, 16'd10, 1'b0);      // positive error, command below the rail
      send_request(OP_UPDATE, 16'd0, 16'd10, 1'b0);      // integral keeps growing, still unpinned
      send_request(OP_UPDATE, 16'hffff, 16'hffff, 1'b0); // big negative error
      send_request(OP_UPDATE, 16'hffff, 16'd1, 1'b0);    // anti-windup low
      send_request(OP_STOP, 16'hffff, 16'hffff, 1'b1);
      send_request(OP_START, 16'hffff, 16'hffff, 1'b1);
      send_request(2'd3, 16'h5555, 16'haaaa, 1'b0);
      wait_drained();
      write_reg(REG_KP, 32'hffffffff);
      write_reg(REG_KI, 32'h7fffffff);
      write_reg(REG_KD, 32'h7fffffff);
      write_reg(REG_SETPOINT, 32'hffff);
      write_reg(REG_MAX, 32'hffff);
      send_request(OP_UPDATE, 16'd0, 16'hffff, 1'b0);    // integral overflow
      send_request(OP_UPDATE, 16'd0, 16'hffff, 1'b0);
      send_request(OP_UPDATE, 16'hffff, 16'd1, 1'b0);
      send_request(OP_UPDATE, 16'h8000, 16'h7fff, 1'b0);
      wait_drained();
      write_reg(REG_KP, 32'd0);
      write_reg(REG_KI, 32'd0);
      write_reg(REG_KD, 32'd0);
      write_reg(REG_MAX, 32'd0);
      send_request(OP_UPDATE, 16'd1, 16'd3, 1'b0);       // max of zero
      send_request(OP_START, 16'd0, 16'd0, 1'b0);
      wait_drained();

      // Random phases, each under fresh settings.
      for (int phase = 0; phase < 12; phase++) begin
         random_config();
         idle_free = (phase == 4);
         for (int n = 0; n < 150; n++) begin
            random_request();
            // occasionally hold off until everything has answered
            if ($urandom_range(99) == 0) begin
               req_valid <= 1'b0;
               @(posedge clock);
               while (loop_model.pending.size() != 0) @(posedge clock);
            end
         end
         wait_drained();
      end
      idle_free = 1'b0;

      wait_drained();
      if (loop_model.err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
